@@ design/pgcm_pkg.sv @@
// Shared types, constants and palette tables for the palette gradient color mapper.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package pgcm_pkg;

  localparam int PALETTE_COUNT = 9;
  localparam int MAX_STOPS     = 10;
  localparam int SEL_W         = 4;
  localparam int STOP_W        = $clog2(MAX_STOPS);
  localparam int CNT_W         = $clog2(MAX_STOPS + 1);
  localparam int NCH           = 3;
  localparam int D_W           = 15;
  localparam int Q_BITS        = 8;
  localparam int REM_W         = D_W + Q_BITS;
  localparam int Q_DEPTH       = 2;

  typedef struct packed {
    logic [7:0] pos;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } stop_t;

  typedef struct packed {
    logic [NCH-1:0][7:0] lo;
    logic [NCH-1:0][7:0] mag;
    logic [NCH-1:0]      neg;
    logic                zero;
    logic [D_W-1:0]      n;
    logic [D_W-1:0]      d;
    logic [7:0]          alpha;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam stop_t SZ = '0;

  localparam logic [CNT_W-1:0] PAL_N [PALETTE_COUNT] = '{
    CNT_W'(7), CNT_W'(7), CNT_W'(7), CNT_W'(7), CNT_W'(7),
    CNT_W'(10), CNT_W'(7), CNT_W'(6), CNT_W'(7)
  };

  localparam stop_t PAL_STOP [PALETTE_COUNT][MAX_STOPS] = '{
    '{ '{8'd0, 8'd0, 8'd0, 8'd0},       '{8'd15, 8'd0, 8'd0, 8'd150},
       '{8'd35, 8'd0, 8'd180, 8'd255},  '{8'd55, 8'd0, 8'd255, 8'd140},
       '{8'd72, 8'd255, 8'd238, 8'd0},  '{8'd87, 8'd255, 8'd120, 8'd0},
       '{8'd100, 8'd255, 8'd34, 8'd0},  SZ, SZ, SZ },
    '{ '{8'd0, 8'd0, 8'd0, 8'd0},       '{8'd15, 8'd20, 8'd5, 8'd40},
       '{8'd35, 8'd90, 8'd15, 8'd100},  '{8'd55, 8'd220, 8'd50, 8'd100},
       '{8'd72, 8'd254, 8'd130, 8'd50}, '{8'd87, 8'd252, 8'd200, 8'd120},
       '{8'd100, 8'd252, 8'd253, 8'd190}, SZ, SZ, SZ },
    '{ '{8'd0, 8'd0, 8'd0, 8'd0},       '{8'd15, 8'd68, 8'd1, 8'd84},
       '{8'd35, 8'd59, 8'd82, 8'd139},  '{8'd55, 8'd33, 8'd145, 8'd140},
       '{8'd72, 8'd94, 8'd201, 8'd98},  '{8'd87, 8'd180, 8'd222, 8'd44},
       '{8'd100, 8'd253, 8'd231, 8'd37}, SZ, SZ, SZ },
    '{ '{8'd0, 8'd0, 8'd0, 8'd0},       '{8'd15, 8'd5, 8'd20, 8'd80},
       '{8'd35, 8'd13, 8'd71, 8'd161},  '{8'd55, 8'd25, 8'd118, 8'd210},
       '{8'd72, 8'd66, 8'd165, 8'd245}, '{8'd87, 8'd144, 8'd202, 8'd249},
       '{8'd100, 8'd255, 8'd255, 8'd255}, SZ, SZ, SZ },
    '{ '{8'd0, 8'd0, 8'd0, 8'd0},       '{8'd15, 8'd80, 8'd5, 8'd5},
       '{8'd35, 8'd161, 8'd13, 8'd13},  '{8'd55, 8'd211, 8'd47, 8'd47},
       '{8'd72, 8'd239, 8'd116, 8'd94}, '{8'd87, 8'd248, 8'd187, 8'd181},
       '{8'd100, 8'd255, 8'd255, 8'd255}, SZ, SZ, SZ },
    '{ '{8'd0, 8'd0, 8'd0, 8'd0},       '{8'd8, 8'd20, 8'd60, 8'd200},
       '{8'd15, 8'd40, 8'd120, 8'd255}, '{8'd30, 8'd120, 8'd190, 8'd255},
       '{8'd42, 8'd200, 8'd230, 8'd255}, '{8'd50, 8'd255, 8'd255, 8'd210},
       '{8'd58, 8'd255, 8'd220, 8'd180}, '{8'd70, 8'd255, 8'd130, 8'd70},
       '{8'd85, 8'd240, 8'd40, 8'd20},  '{8'd100, 8'd160, 8'd0, 8'd0} },
    '{ '{8'd0, 8'd0, 8'd0, 8'd0},       '{8'd15, 8'd74, 8'd0, 8'd0},
       '{8'd35, 8'd170, 8'd17, 8'd0},   '{8'd55, 8'd255, 8'd68, 8'd0},
       '{8'd72, 8'd255, 8'd153, 8'd0},  '{8'd87, 8'd255, 8'd238, 8'd0},
       '{8'd100, 8'd255, 8'd255, 8'd255}, SZ, SZ, SZ },
    '{ '{8'd0, 8'd26, 8'd0, 8'd48},     '{8'd15, 8'd90, 8'd0, 8'd96},
       '{8'd35, 8'd204, 8'd0, 8'd102},  '{8'd55, 8'd255, 8'd102, 8'd0},
       '{8'd72, 8'd255, 8'd204, 8'd0},  '{8'd100, 8'd255, 8'd255, 8'd170},
       SZ, SZ, SZ, SZ },
    '{ '{8'd0, 8'd0, 8'd0, 8'd0},       '{8'd15, 8'd42, 8'd10, 8'd0},
       '{8'd35, 8'd120, 8'd40, 8'd0},   '{8'd55, 8'd210, 8'd95, 8'd0},
       '{8'd72, 8'd255, 8'd165, 8'd0},  '{8'd87, 8'd255, 8'd215, 8'd80},
       '{8'd100, 8'd255, 8'd248, 8'd200}, SZ, SZ, SZ }
  };

endpackage

@@ design/pgcm_front.sv @@
// Front stage: accepts levels, finds the palette segment and prepares the interpolation job.
// Depends on pgcm_pkg for the palette tables and the job type.
`timescale 1ns / 1ps

module pgcm_front
  import pgcm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [SEL_W-1:0] sel,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_level,
  output logic             job_valid,
  input  logic             job_ready,
  output job_t             job
);

  localparam int           ALPHA_SHIFT = 12;
  localparam logic [19:0]  ALPHA_RECIP = 20'd1366;
  localparam logic [7:0]   ALPHA_SAT   = 8'd39;

  logic             v_r;
  job_t             job_r;
  job_t             job_nxt;

  logic [SEL_W-1:0]  psel;
  logic [CNT_W-1:0]  cnt;
  logic [D_W-1:0]    x;
  logic [D_W-1:0]    ps [MAX_STOPS];
  logic [STOP_W-1:0] lo_i;
  logic [STOP_W-1:0] hi_i;
  stop_t             s_lo;
  stop_t             s_hi;
  logic [8:0]        wd;
  logic [D_W-1:0]    ps_lo;
  logic [D_W-1:0]    nn;
  logic [NCH-1:0][7:0] c_lo;
  logic [NCH-1:0][7:0] c_hi;
  logic [9:0]        a20;
  logic [19:0]       aq;

  always_comb begin
    psel = (sel < SEL_W'(PALETTE_COUNT)) ? sel : '0;
    cnt  = PAL_N[psel];
    x    = D_W'(in_level) * D_W'(100);
    for (int k = 0; k < MAX_STOPS; k++) begin
      ps[k] = D_W'(PAL_STOP[psel][k].pos) * D_W'(255);
    end
    lo_i = '0;
    hi_i = STOP_W'(cnt - CNT_W'(1));
    // first matching segment wins
    for (int k = MAX_STOPS - 2; k >= 0; k--) begin
      if ((CNT_W'(k + 1) < cnt) && (x >= ps[k]) && (x <= ps[k + 1])) begin
        lo_i = STOP_W'(k);
        hi_i = STOP_W'(k + 1);
      end
    end
    s_lo  = PAL_STOP[psel][lo_i];
    s_hi  = PAL_STOP[psel][hi_i];
    wd    = {1'b0, s_hi.pos} - {1'b0, s_lo.pos};
    ps_lo = D_W'(s_lo.pos) * D_W'(255);

    job_nxt      = '0;
    job_nxt.zero = wd[8] || (wd == '0);
    job_nxt.d    = D_W'(wd[7:0]) * D_W'(255);
    nn = (x > ps_lo) ? (x - ps_lo) : '0;
    if (!job_nxt.zero && (nn > job_nxt.d)) begin
      nn = job_nxt.d;
    end
    job_nxt.n = nn;

    c_lo[0] = s_lo.r;
    c_lo[1] = s_lo.g;
    c_lo[2] = s_lo.b;
    c_hi[0] = s_hi.r;
    c_hi[1] = s_hi.g;
    c_hi[2] = s_hi.b;
    for (int c = 0; c < NCH; c++) begin
      job_nxt.lo[c] = c_lo[c];
      if (c_hi[c] >= c_lo[c]) begin
        job_nxt.mag[c] = c_hi[c] - c_lo[c];
        job_nxt.neg[c] = 1'b0;
      end else begin
        job_nxt.mag[c] = c_lo[c] - c_hi[c];
        job_nxt.neg[c] = 1'b1;
      end
    end

    // divide by three through a reciprocal, exact below saturation
    a20 = 10'(in_level) * 10'd20;
    aq  = 20'(a20) * ALPHA_RECIP;
    job_nxt.alpha = (in_level >= ALPHA_SAT) ? 8'hFF : aq[ALPHA_SHIFT +: 8];
  end

  assign in_ready  = !v_r || job_ready;
  assign job_valid = v_r;
  assign job       = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      job_r <= job_nxt;
    end
  end

endmodule

@@ design/pgcm_queue.sv @@
// Short job queue between the front and back stages.
// Depends on pgcm_pkg for the job and status types.
`timescale 1ns / 1ps

module pgcm_queue
  import pgcm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_valid,
  output logic    push_ready,
  input  job_t    push_data,
  output logic    pop_valid,
  input  logic    pop_ready,
  output job_t    pop_data,
  output q_stat_t stat
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QC_W  = $clog2(Q_DEPTH + 1);

  job_t             slot_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [QC_W-1:0]  cnt_r;
  logic             push;
  logic             pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign stat.full  = (cnt_r == QC_W'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign push_ready = !stat.full;
  assign pop_valid  = !stat.empty;
  assign pop_data   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QC_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ design/pgcm_back.sv @@
// Back stage: pipelined restoring divider, one quotient bit per stage, and the output register.
// Depends on pgcm_pkg for the job type and widths.
`timescale 1ns / 1ps

module pgcm_back
  import pgcm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       job_valid,
  output logic       job_ready,
  input  job_t       job,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha
);

  localparam int NST = Q_BITS + 1;

  typedef struct packed {
    logic [NCH-1:0][7:0]        lo;
    logic [NCH-1:0]             neg;
    logic                       zero;
    logic [D_W-1:0]             d;
    logic [7:0]                 alpha;
    logic [NCH-1:0][REM_W-1:0]  rem;
    logic [NCH-1:0][Q_BITS-1:0] q;
  } stage_t;

  logic [NST-1:0]      st_v_r;
  stage_t              st_r [NST];
  logic [NST:0]        rdy;
  stage_t              ld;
  stage_t              fin;
  logic [NCH-1:0][7:0] res;
  logic                out_v_r;
  logic [NCH-1:0][7:0] res_r;
  logic [7:0]          alpha_r;

  function automatic stage_t div_step(input stage_t s, input int b);
    stage_t         t;
    logic [REM_W-1:0] dsh;
    t   = s;
    dsh = REM_W'(s.d) << b;
    for (int c = 0; c < NCH; c++) begin
      if (s.rem[c] >= dsh) begin
        t.rem[c]    = s.rem[c] - dsh;
        t.q[c][b]   = 1'b1;
      end
    end
    return t;
  endfunction

  always_comb begin
    ld       = '0;
    ld.lo    = job.lo;
    ld.neg   = job.neg;
    ld.zero  = job.zero;
    ld.d     = job.d;
    ld.alpha = job.alpha;
    for (int c = 0; c < NCH; c++) begin
      // descending channel: bias the dividend to round the quotient up
      if (job.zero) begin
        ld.rem[c] = '0;
      end else if (job.neg[c]) begin
        ld.rem[c] = REM_W'(job.n) * REM_W'(job.mag[c]) + REM_W'(job.d) - REM_W'(1);
      end else begin
        ld.rem[c] = REM_W'(job.n) * REM_W'(job.mag[c]);
      end
    end
  end

  always_comb begin
    rdy[NST] = !out_v_r || out_ready;
    for (int i = NST - 1; i >= 0; i--) begin
      rdy[i] = !st_v_r[i] || rdy[i + 1];
    end
  end

  always_comb begin
    fin = st_r[NST-1];
    for (int c = 0; c < NCH; c++) begin
      if (fin.zero) begin
        res[c] = fin.lo[c];
      end else if (fin.neg[c]) begin
        res[c] = fin.lo[c] - fin.q[c];
      end else begin
        res[c] = fin.lo[c] + fin.q[c];
      end
    end
  end

  assign job_ready = rdy[0];
  assign out_valid = out_v_r;
  assign out_red   = res_r[0];
  assign out_green = res_r[1];
  assign out_blue  = res_r[2];
  assign out_alpha = alpha_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_v_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy[0]) begin
        st_v_r[0] <= job_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (rdy[i]) begin
          st_v_r[i] <= st_v_r[i - 1];
        end
      end
      if (rdy[NST]) begin
        out_v_r <= st_v_r[NST-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && job_valid) begin
      st_r[0] <= ld;
    end
    for (int i = 1; i < NST; i++) begin
      if (rdy[i] && st_v_r[i - 1]) begin
        st_r[i] <= div_step(st_r[i - 1], Q_BITS - i);
      end
    end
    if (rdy[NST] && st_v_r[NST-1]) begin
      res_r   <= res;
      alpha_r <= fin.alpha;
    end
  end

endmodule

@@ design/palette_gradient_color_mapper.sv @@
// Palette gradient color mapper: an 8-bit level in, an RGBA color out.
// Input channel in_valid/in_ready/in_level; result channel out_valid/out_ready with
// out_red, out_green, out_blue, out_alpha; cfg_we/cfg_wdata writes the palette selector.
// Throughput: one level per cycle while out_ready is high, set by the one-bit-per-stage
// divider pipeline in the back stage (eight stages) and the combinational segment search
// in the front stage.
// A two-entry queue sits between front and back; when out_ready is low the back
// pipeline fills, then the queue, then in_ready drops; nothing is lost or repeated.
// Reset clears all valid flags and selects palette 0; no clearing pass is needed.
// Selector values past the last palette select palette 0.
// Depends on pgcm_pkg, pgcm_front, pgcm_queue and pgcm_back.
`timescale 1ns / 1ps

module palette_gradient_color_mapper
  import pgcm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [SEL_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_level,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic [7:0]       out_alpha
);

  logic [SEL_W-1:0] sel_r;
  logic [SEL_W-1:0] sel_nxt;
  logic             fr_valid;
  logic             fr_ready;
  job_t             fr_job;
  logic             bk_valid;
  logic             bk_ready;
  job_t             bk_job;
  q_stat_t          q_stat;

  assign sel_nxt = cfg_we ? cfg_wdata : sel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= '0;
    end else begin
      sel_r <= sel_nxt;
    end
  end

  pgcm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .sel       (sel_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_level  (in_level),
    .job_valid (fr_valid),
    .job_ready (fr_ready),
    .job       (fr_job)
  );

  pgcm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_data  (fr_job),
    .pop_valid  (bk_valid),
    .pop_ready  (bk_ready),
    .pop_data   (bk_job),
    .stat       (q_stat)
  );

  pgcm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (bk_valid),
    .job_ready (bk_ready),
    .job       (bk_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_alpha (out_alpha)
  );

`ifndef SYNTHESIS
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_empty_queue_ready: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty |-> in_ready)
    else $error("input stalled while queue empty");

  a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue both full and empty");
`endif

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for palette_gradient_color_mapper: levels flow through a
// valid/ready driver, results are checked against a local gradient predictor.
// Depends on pgcm_pkg (selector width, palette count, stop count) and the DUT RTL only.
`timescale 1ns / 1ps

module tb_top
  import pgcm_pkg::*;
();

  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 12;

  typedef enum logic [SEL_W-1:0] {
    PAL_THERMAL, PAL_INFERNO, PAL_VIRIDIS, PAL_BLUE, PAL_RED,
    PAL_DOMINANCE, PAL_LAVA, PAL_SUNSET, PAL_AMBER
  } palette_e;

  typedef struct packed {
    logic [7:0] pos;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } grad_stop_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  localparam int GRAD_STOP_COUNT [PALETTE_COUNT] = '{7, 7, 7, 7, 7, 10, 7, 6, 7};

  localparam grad_stop_t GRAD_STOP [PALETTE_COUNT][MAX_STOPS] = '{
    '{ '{0, 0, 0, 0}, '{15, 0, 0, 150}, '{35, 0, 180, 255}, '{55, 0, 255, 140},
       '{72, 255, 238, 0}, '{87, 255, 120, 0}, '{100, 255, 34, 0},
       '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0} },
    '{ '{0, 0, 0, 0}, '{15, 20, 5, 40}, '{35, 90, 15, 100}, '{55, 220, 50, 100},
       '{72, 254, 130, 50}, '{87, 252, 200, 120}, '{100, 252, 253, 190},
       '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0} },
    '{ '{0, 0, 0, 0}, '{15, 68, 1, 84}, '{35, 59, 82, 139}, '{55, 33, 145, 140},
       '{72, 94, 201, 98}, '{87, 180, 222, 44}, '{100, 253, 231, 37},
       '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0} },
    '{ '{0, 0, 0, 0}, '{15, 5, 20, 80}, '{35, 13, 71, 161}, '{55, 25, 118, 210},
       '{72, 66, 165, 245}, '{87, 144, 202, 249}, '{100, 255, 255, 255},
       '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0} },
    '{ '{0, 0, 0, 0}, '{15, 80, 5, 5}, '{35, 161, 13, 13}, '{55, 211, 47, 47},
       '{72, 239, 116, 94}, '{87, 248, 187, 181}, '{100, 255, 255, 255},
       '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0} },
    '{ '{0, 0, 0, 0}, '{8, 20, 60, 200}, '{15, 40, 120, 255}, '{30, 120, 190, 255},
       '{42, 200, 230, 255}, '{50, 255, 255, 210}, '{58, 255, 220, 180},
       '{70, 255, 130, 70}, '{85, 240, 40, 20}, '{100, 160, 0, 0} },
    '{ '{0, 0, 0, 0}, '{15, 74, 0, 0}, '{35, 170, 17, 0}, '{55, 255, 68, 0},
       '{72, 255, 153, 0}, '{87, 255, 238, 0}, '{100, 255, 255, 255},
       '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0} },
    '{ '{0, 26, 0, 48}, '{15, 90, 0, 96}, '{35, 204, 0, 102}, '{55, 255, 102, 0},
       '{72, 255, 204, 0}, '{100, 255, 255, 170},
       '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0} },
    '{ '{0, 0, 0, 0}, '{15, 42, 10, 0}, '{35, 120, 40, 0}, '{55, 210, 95, 0},
       '{72, 255, 165, 0}, '{87, 255, 215, 80}, '{100, 255, 248, 200},
       '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0} }
  };

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [SEL_W-1:0] cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       in_level = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [7:0]       out_red;
  logic [7:0]       out_green;
  logic [7:0]       out_blue;
  logic [7:0]       out_alpha;

  logic [7:0]       level_pending_q [$];
  rgba_t            color_expect_q [$];
  logic [SEL_W-1:0] palette_copy;
  bit               send_idle = 1'b0;
  bit               recv_idle = 1'b0;
  int               send_gap = 0;
  int               recv_stall = 0;
  int               stall_draw;
  int               mismatch_count = 0;
  int               quiet_cycles = 0;

  palette_gradient_color_mapper u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_level  (in_level),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_alpha (out_alpha)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] blend_channel(input int lo, input int hi, input int d,
                                               input int n);
    int num;
    if (d <= 0) return lo[7:0];
    num = lo * d + n * (hi - lo);
    if (num < 0) num = 0;
    return 8'((num / d) & 255);
  endfunction

  function automatic rgba_t map_level_to_rgba(input logic [SEL_W-1:0] sel,
                                              input logic [7:0] lvl);
    int         idx;
    int         lo_i;
    int         hi_i;
    int         x;
    int         d;
    int         n;
    int         a;
    bit         found;
    grad_stop_t s_lo;
    grad_stop_t s_hi;
    rgba_t      c;
    idx = (sel < PALETTE_COUNT) ? int'(sel) : int'(PAL_THERMAL);
    lo_i = 0;
    hi_i = GRAD_STOP_COUNT[idx] - 1;
    x = 100 * int'(lvl);
    found = 1'b0;
    for (int k = 0; k + 1 < GRAD_STOP_COUNT[idx]; k++) begin
      if (!found && x >= 255 * int'(GRAD_STOP[idx][k].pos) &&
          x <= 255 * int'(GRAD_STOP[idx][k+1].pos)) begin
        lo_i = k;
        hi_i = k + 1;
        found = 1'b1;
      end
    end
    s_lo = GRAD_STOP[idx][lo_i];
    s_hi = GRAD_STOP[idx][hi_i];
    d = 255 * (int'(s_hi.pos) - int'(s_lo.pos));
    n = x - 255 * int'(s_lo.pos);
    if (n < 0) n = 0;
    if (d > 0 && n > d) n = d;
    c.red   = blend_channel(s_lo.r, s_hi.r, d, n);
    c.green = blend_channel(s_lo.g, s_hi.g, d, n);
    c.blue  = blend_channel(s_lo.b, s_hi.b, d, n);
    a = (20 * int'(lvl)) / 3;
    c.alpha = (a > 255) ? 8'd255 : a[7:0];
    return c;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (in_valid && !in_ready) begin
      // hold until the transfer
    end else if (send_gap != 0) begin
      in_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (level_pending_q.size() != 0) begin
      in_valid <= 1'b1;
      in_level <= level_pending_q.pop_front();
      send_gap <= send_idle ? $urandom_range(0, 9) : 0;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result sink
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_stall <= 0;
    end else if (out_valid && out_ready) begin
      stall_draw = recv_idle ? $urandom_range(0, 9) : 0;
      if (stall_draw != 0) begin
        out_ready <= 1'b0;
        recv_stall <= stall_draw - 1;
      end
    end else if (recv_stall != 0) begin
      recv_stall <= recv_stall - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic check_channel(input string label, input logic [7:0] expected,
                               input logic [7:0] actual);
    if (actual !== expected) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, expected, actual);
      mismatch_count++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    rgba_t exp_c;
    if (!rst_n) begin
      palette_copy <= PAL_THERMAL;
    end else begin
      if (cfg_we) palette_copy <= cfg_wdata;
      if (in_valid && in_ready) begin
        color_expect_q.push_back(map_level_to_rgba(palette_copy, in_level));
      end
      if (out_valid && out_ready) begin
        if (color_expect_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d %0d %0d %0d", $time,
                   out_red, out_green, out_blue, out_alpha);
          mismatch_count++;
        end else begin
          exp_c = color_expect_q.pop_front();
          check_channel("red", exp_c.red, out_red);
          check_channel("green", exp_c.green, out_green);
          check_channel("blue", exp_c.blue, out_blue);
          check_channel("alpha", exp_c.alpha, out_alpha);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("palette_gradient_color_mapper verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_drained();
    @(negedge clk);
    while (level_pending_q.size() != 0 || in_valid || color_expect_q.size() != 0)
      @(negedge clk);
  endtask

  task automatic select_palette(input logic [SEL_W-1:0] sel);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= sel;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [7:0] sweep [$];
    int         sel_order [16];
    int         j;
    int         tmp;
    int         idx;
    int         k;
    int         lvl;
    sweep = '{8'd0, 8'd1, 8'd2, 8'd38, 8'd39, 8'd40, 8'd76, 8'd77, 8'd89, 8'd90, 8'd127,
              8'd128, 8'd140, 8'd141, 8'd183, 8'd184, 8'd221, 8'd222, 8'd253, 8'd254,
              8'd255};
    for (int i = 0; i < 16; i++) sel_order[i] = i;
    for (int i = 15; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = sel_order[i];
      sel_order[i] = sel_order[j];
      sel_order[j] = tmp;
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // segment edges, alpha knee and range ends on the default palette
    select_palette(PAL_THERMAL);
    foreach (sweep[i]) level_pending_q.push_back(sweep[i]);

    // selector past the last palette falls back to the first one
    select_palette(4'hF);
    send_idle = 1'b1;
    recv_idle = 1'b1;
    level_pending_q.push_back(8'd0);
    level_pending_q.push_back(8'd128);
    level_pending_q.push_back(8'd255);

    foreach (sel_order[p]) begin
      select_palette(sel_order[p][SEL_W-1:0]);
      send_idle = $urandom_range(0, 3) != 0;
      recv_idle = $urandom_range(0, 3) != 0;
      idx = (sel_order[p] < PALETTE_COUNT) ? sel_order[p] : int'(PAL_THERMAL);
      for (int i = 0; i < 98; i++) begin
        if ($urandom_range(0, 3) == 0) begin
          k = $urandom_range(0, GRAD_STOP_COUNT[idx] - 1);
          lvl = (255 * int'(GRAD_STOP[idx][k].pos)) / 100 + $urandom_range(0, 1);
          if (lvl > 255) lvl = 255;
          level_pending_q.push_back(lvl[7:0]);
        end else begin
          level_pending_q.push_back(8'($urandom_range(0, 255)));
        end
      end
    end

    wait_drained();
    repeat (2 * DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && color_expect_q.size() == 0) begin
      $display("palette_gradient_color_mapper verification clean");
    end else begin
      $display("palette_gradient_color_mapper verification failed");
    end
    $finish;
  end

endmodule
